FILE: design/sbq_pkg.sv
package sbq_pkg;

    localparam int COEF_W     = 32;
    localparam int OUT_HIST_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_A0,
        COEF_A1,
        COEF_A2,
        COEF_B1,
        COEF_B2
    } t_coef_idx;

endpackage

FILE: design/stereo_biquad_iir.sv
// Two-channel second-order IIR filter, direct form I, for signed audio samples.
// Input items carry a sample and a channel select. Output items carry the
// filtered sample saturated to SAMPLE_BITS, the channel used and a clip flag.
// Both channels use valid/ready; the coefficient port is a plain write port
// (enable, index, data) in signed fixed point with COEFF_FRAC_BITS fraction bits.
// The user must write coefficients only while no item is in flight; the
// block itself does not enforce this. An accepted item enters an input
// register; there the five products, their sum, rounding and saturation are
// formed in one pass, and when the output register is free the result is
// loaded into it while the channel history updates. Throughput is one item
// per cycle while the receiver takes results; that rate is set by the
// combinational feedback path through the multipliers and the accumulator
// into the history registers, which lets an item of the same channel follow.
// When the receiver stalls, the result waits in the output register and one
// more item waits in the input register; input ready drops only when both
// are full. Reset clears the channel history, sets the gain on the current
// input to one and all other coefficients to zero, and empties both registers.
module stereo_biquad_iir #(
    parameter int COEFF_FRAC_BITS = 29,
    parameter int SAMPLE_BITS     = 24,
    parameter int NUM_CHANNELS    = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sbq_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic                                i_channel,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                                o_channel_out,
    output logic                                o_clipped
);
    import sbq_pkg::*;

    localparam int NUM_HIST = (NUM_CHANNELS > 2) ? 2 : NUM_CHANNELS;
    localparam int PROD_W   = COEF_W + OUT_HIST_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int Y_W      = ACC_W - COEFF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic [COEF_W-1:0]       UNITY      = COEF_W'(1) << COEFF_FRAC_BITS;

    logic signed [COEF_W-1:0]      r_coef_a0, r_coef_a1, r_coef_a2, r_coef_b1, r_coef_b2;
    logic                          r_in_vld;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x1 [NUM_HIST];
    logic signed [SAMPLE_BITS-1:0] r_x2 [NUM_HIST];
    logic signed [OUT_HIST_W-1:0]  r_y1 [NUM_HIST];
    logic signed [OUT_HIST_W-1:0]  r_y2 [NUM_HIST];
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_ch;
    logic                          r_out_clip;

    logic                          fire;
    logic                          n_ch;
    logic signed [SAMPLE_BITS-1:0] h_x1, h_x2;
    logic signed [OUT_HIST_W-1:0]  h_y1, h_y2;
    logic signed [PROD_W-1:0]      p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]       acc;
    logic signed [Y_W-1:0]         y;
    logic                          fits32, fits_s;
    logic signed [OUT_HIST_W-1:0]  y32;
    logic signed [SAMPLE_BITS-1:0] y_s;

    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;
    assign n_ch       = (NUM_HIST > 1) ? i_channel : 1'b0;

    assign h_x1 = r_x1[r_ch];
    assign h_x2 = r_x2[r_ch];
    assign h_y1 = r_y1[r_ch];
    assign h_y2 = r_y2[r_ch];

    assign p0 = PROD_W'(r_coef_a0) * PROD_W'(r_x);
    assign p1 = PROD_W'(r_coef_a1) * PROD_W'(h_x1);
    assign p2 = PROD_W'(r_coef_a2) * PROD_W'(h_x2);
    assign p3 = PROD_W'(r_coef_b1) * PROD_W'(h_y1);
    assign p4 = PROD_W'(r_coef_b2) * PROD_W'(h_y2);

    assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4) + ROUND_HALF;
    assign y   = $signed(acc[ACC_W-1:COEFF_FRAC_BITS]);

    assign fits32 = (&y[Y_W-1:OUT_HIST_W-1]) || !(|y[Y_W-1:OUT_HIST_W-1]);
    assign fits_s = (&y[Y_W-1:SAMPLE_BITS-1]) || !(|y[Y_W-1:SAMPLE_BITS-1]);
    assign y32 = fits32 ? y[OUT_HIST_W-1:0] : {y[Y_W-1], {(OUT_HIST_W-1){~y[Y_W-1]}}};
    assign y_s = fits_s ? y[SAMPLE_BITS-1:0] : {y[Y_W-1], {(SAMPLE_BITS-1){~y[Y_W-1]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a0 <= UNITY;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
        end else if (i_cfg_we) begin
            case (t_coef_idx'(i_cfg_index))
                COEF_A0: r_coef_a0 <= i_cfg_data;
                COEF_A1: r_coef_a1 <= i_cfg_data;
                COEF_A2: r_coef_a2 <= i_cfg_data;
                COEF_B1: r_coef_b1 <= i_cfg_data;
                COEF_B2: r_coef_b2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_HIST; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld  <= 1'b1;
                r_x2[r_ch] <= h_x1;
                r_x1[r_ch] <= r_x;
                r_y2[r_ch] <= h_y1;
                r_y1[r_ch] <= y32;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_x  <= i_sample_in;
            r_ch <= n_ch;
        end
        if (fire) begin
            r_out_sample <= y_s;
            r_out_ch     <= r_ch;
            r_out_clip   <= !fits_s;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_sample_out  = r_out_sample;
    assign o_channel_out = r_out_ch;
    assign o_clipped     = r_out_clip;

endmodule

FILE: design/sbq_checker.sv
module sbq_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic                          o_channel_out,
    input logic                          o_clipped
);

    // A result held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_sample_out) && $stable(o_channel_out) && $stable(o_clipped))
        else $error("stalled result changed");

    // A clipped result sits at one of the two rails.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            (o_sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
            (o_sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("clip flag without saturated sample");

    // Every accepted item is followed by a result on offer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("no result after accepted item");

    // Reset leaves no result on offer.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind stereo_biquad_iir sbq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbq_checker (.*);

FILE: tb/stereo_biquad_iir_tb.sv
`timescale 1ns / 100ps

module stereo_biquad_iir_tb;

    import sbq_pkg::*;

    localparam int FRAC            = 29;
    localparam int SW              = 24;
    localparam int NUM_CH          = 2;
    localparam int NUM_COEFS       = int'(COEF_B2) + 1;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 12;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 100000;

    localparam logic signed [95:0] OUT_MAX  = (96'sd1 <<< (SW - 1)) - 96'sd1;
    localparam logic signed [95:0] OUT_MIN  = -(96'sd1 <<< (SW - 1));
    localparam logic signed [95:0] HIST_MAX = (96'sd1 <<< (OUT_HIST_W - 1)) - 96'sd1;
    localparam logic signed [95:0] HIST_MIN = -(96'sd1 <<< (OUT_HIST_W - 1));

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

    localparam logic [COEF_W-1:0] COEF_MAX       = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN       = 32'h8000_0000;
    localparam logic [COEF_W-1:0] COEF_UNITY     = 32'h2000_0000;
    localparam logic [COEF_W-1:0] COEF_NEG_UNITY = 32'hE000_0000;
    localparam logic [COEF_W-1:0] COEF_HALF      = 32'h1000_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;
    typedef enum int {MIX_RANDOM, MIX_STABLE, MIX_EXTREME} t_coef_mix;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] t_coef_set;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 channel;
        logic                 clip;
    } t_filt_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COEF_W-1:0]      i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [SW-1:0]   i_sample_in;
    logic                   i_channel;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [SW-1:0]   o_sample_out;
    logic                   o_channel_out;
    logic                   o_clipped;

    logic signed [COEF_W-1:0]     coef_model [NUM_COEFS];
    logic signed [SW-1:0]         x_hist_one [NUM_CH];
    logic signed [SW-1:0]         x_hist_two [NUM_CH];
    logic signed [OUT_HIST_W-1:0] y_hist_one [NUM_CH];
    logic signed [OUT_HIST_W-1:0] y_hist_two [NUM_CH];

    t_filt_sample pending_outputs [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_accepted     = 0;
    int n_checked      = 0;
    int n_clipped      = 0;
    int n_cycles       = 0;

    stereo_biquad_iir #(
        .COEFF_FRAC_BITS(FRAC),
        .SAMPLE_BITS(SW),
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_in(i_sample_in),
        .i_channel(i_channel),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_sample_out(o_sample_out),
        .o_channel_out(o_channel_out),
        .o_clipped(o_clipped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // The exact sum is rounded half up, kept at 32 bits as history and clipped to
    // the sample width for the result.
    task automatic biquad_predict(input logic signed [SW-1:0] x, input logic ch);
        logic signed [95:0]           acc;
        logic signed [95:0]           y_full;
        logic signed [OUT_HIST_W-1:0] y_sat;
        t_filt_sample                 r;
        int                           c;
        c = int'(ch);
        acc = coef_model[COEF_A0] * x
            + coef_model[COEF_A1] * x_hist_one[c]
            + coef_model[COEF_A2] * x_hist_two[c]
            - coef_model[COEF_B1] * y_hist_one[c]
            - coef_model[COEF_B2] * y_hist_two[c]
            + (96'sd1 <<< (FRAC - 1));
        y_full = acc >>> FRAC;
        if (y_full > HIST_MAX) begin
            y_sat = HIST_MAX[OUT_HIST_W-1:0];
        end else if (y_full < HIST_MIN) begin
            y_sat = HIST_MIN[OUT_HIST_W-1:0];
        end else begin
            y_sat = y_full[OUT_HIST_W-1:0];
        end
        r.channel = ch;
        r.clip    = 1'b1;
        if (y_full > OUT_MAX) begin
            r.sample = SAMPLE_MAX;
        end else if (y_full < OUT_MIN) begin
            r.sample = SAMPLE_MIN;
        end else begin
            r.sample = y_full[SW-1:0];
            r.clip   = 1'b0;
        end
        if (r.clip) n_clipped++;
        pending_outputs.push_back(r);
        x_hist_two[c] = x_hist_one[c];
        x_hist_one[c] = x;
        y_hist_two[c] = y_hist_one[c];
        y_hist_one[c] = y_sat;
    endtask

    always @(posedge i_clk) begin
        t_filt_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("Unexpected item: sample_out %0d, channel_out %0d, clipped %0d",
                       o_sample_out, o_channel_out, o_clipped);
                n_errors++;
            end else begin
                want = pending_outputs.pop_front();
                n_checked++;
                if (o_sample_out !== want.sample) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           want.sample, o_sample_out);
                    n_errors++;
                end
                if (o_channel_out !== want.channel) begin
                    $error("channel_out mismatch: expected %0d, actual %0d",
                           want.channel, o_channel_out);
                    n_errors++;
                end
                if (o_clipped !== want.clip) begin
                    $error("clipped mismatch: expected %0d, actual %0d",
                           want.clip, o_clipped);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] x, input logic ch);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        i_channel   <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        biquad_predict(x, ch);
        n_accepted++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_coefs(input t_coef_set cs, input bit poke_unused);
        for (int i = 0; i < NUM_COEFS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_coef_idx'(i);
            i_cfg_data  <= cs[i];
            @(posedge i_clk);
            coef_model[i] = cs[i];
        end
        if (poke_unused) begin
            for (int i = NUM_COEFS; i < 2 ** CFG_IDX_W; i++) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(i);
                i_cfg_data  <= $urandom;
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default: begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
        endcase
    endtask

    function automatic logic signed [SW-1:0] random_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: begin
                v = int'($urandom_range(0, 128)) - 64;
                return v[SW-1:0];
            end
            default: return SW'($urandom);
        endcase
    endfunction

    // Stable sets keep the poles inside the unit circle so that the filter
    // spends most of its time out of saturation.
    function automatic t_coef_set pick_coefs(input t_coef_mix mix);
        t_coef_set cs;
        int        b2;
        int        mag;
        for (int i = 0; i < NUM_COEFS; i++) begin
            case (mix)
                MIX_RANDOM: cs[i] = $urandom;
                MIX_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0: cs[i] = COEF_MAX;
                        1: cs[i] = COEF_MIN;
                        2: cs[i] = COEF_UNITY;
                        3: cs[i] = COEF_NEG_UNITY;
                        default: cs[i] = '0;
                    endcase
                end
                default: cs[i] = COEF_W'($urandom_range(0, 1 << 29) - (1 << 28));
            endcase
        end
        if (mix == MIX_STABLE) begin
            b2  = $urandom_range(0, 429496729);
            mag = $urandom_range(0, (1 << 29) + b2 - (1 << 26));
            cs[COEF_B2] = b2;
            cs[COEF_B1] = $urandom_range(0, 1) ? -mag : mag;
        end
        return cs;
    endfunction

    task automatic test_passthrough();
        send_sample('0, 1'b0);
        send_sample(SW'(1), 1'b1);
        send_sample(-SW'(1), 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(24'h555555, 1'b1);
        send_sample(24'hAAAAAA, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        drain_results();
    endtask

    // A gain of one half puts odd inputs exactly on a rounding tie.
    task automatic test_rounding();
        t_coef_set cs;
        cs = '0;
        cs[COEF_A0] = COEF_HALF;
        load_coefs(cs, 1'b1);
        send_sample(SW'(1), 1'b0);
        send_sample(-SW'(1), 1'b1);
        send_sample(SW'(3), 1'b0);
        send_sample(-SW'(3), 1'b1);
        drain_results();
    endtask

    // Full-scale gains drive the sum past 64 bits and the output history into
    // 32-bit saturation.
    task automatic test_saturation();
        t_coef_set cs;
        cs[COEF_A0] = COEF_MAX;
        cs[COEF_A1] = COEF_MIN;
        cs[COEF_A2] = COEF_MAX;
        cs[COEF_B1] = COEF_MIN;
        cs[COEF_B2] = COEF_MAX;
        load_coefs(cs, 1'b0);
        for (int i = 0; i < 5; i++) send_sample(SAMPLE_MAX, 1'b0);
        for (int i = 0; i < 5; i++) send_sample(SAMPLE_MIN, 1'b1);
        drain_results();
    endtask

    task automatic test_random_filters();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_idling(t_idle'(ph % 4));
            load_coefs(pick_coefs(t_coef_mix'(ph % 3)), ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) drain_results();
                send_sample(random_sample(), 1'($urandom_range(0, 1)));
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;
        i_channel   <= 1'b0;
        for (int i = 0; i < NUM_COEFS; i++) coef_model[i] = '0;
        coef_model[COEF_A0] = COEF_UNITY;
        for (int c = 0; c < NUM_CH; c++) begin
            x_hist_one[c] = '0;
            x_hist_two[c] = '0;
            y_hist_one[c] = '0;
            y_hist_two[c] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_rounding();
        test_saturation();
        test_random_filters();

        $display("Covered %0d items: pass-through, rounding ties, full-scale saturation,",
                 n_accepted);
        $display("and %0d random filter phases; %0d results checked, %0d clipped.",
                 NUM_PHASES, n_checked, n_clipped);
        if (n_errors == 0 && pending_outputs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
design/sbq_pkg.sv
design/stereo_biquad_iir.sv
design/sbq_checker.sv
tb/stereo_biquad_iir_tb.sv
